// ===== rtl/teq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants of the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int ELEMENTS  = 32;
    localparam int TIME_BITS = 63;
    localparam int IDX_W     = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int CNT_W     = $clog2(ELEMENTS + 1);
    localparam int SUM_W     = 64;
    localparam logic [SUM_W-1:0] MAX_TIME = (SUM_W'(1) << TIME_BITS) - SUM_W'(1);

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_POP      = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_SCHEDULED   = 3'd0,
        ST_REPEATED    = 3'd1,
        ST_INACTIVE    = 3'd2,
        ST_CANCELLED   = 3'd3,
        ST_NOT_PENDING = 3'd4,
        ST_POPPED      = 3'd5,
        ST_NONE        = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  element;
        logic [61:0] delay;
        logic [62:0] limit_time;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  event_element;
        logic [62:0] event_time;
        logic [62:0] now_time;
        logic [5:0]  queue_count;
    } t_rsp;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_POP,
        CELL_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [TIME_BITS-1:0]   stamp;
        logic [4:0]             element;
    } t_cell_cmd;

    typedef struct packed {
        logic                   valid;
        logic [TIME_BITS-1:0]   stamp;
        logic [4:0]             element;
    } t_slot;

endpackage

// ===== rtl/teq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_cell
// One slot of the sorted queue; shifts toward either neighbor on command.
// ----------------------------------------------------------------------------
module teq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  teq_pkg::t_cell_cmd i_cmd,
    input  teq_pkg::t_slot     i_left,
    input  teq_pkg::t_slot     i_right,
    input  logic               i_left_lt,
    input  logic               i_left_match,
    output teq_pkg::t_slot     o_slot,
    output logic               o_lt,
    output logic               o_match
);
    import teq_pkg::*;

    logic                 r_valid, n_valid;
    logic [TIME_BITS-1:0] r_stamp, n_stamp;
    logic [4:0]           r_elem,  n_elem;

    assign o_lt    = r_valid && (r_stamp < i_cmd.stamp);
    assign o_match = i_left_match || (r_valid && (r_elem == i_cmd.element));

    always_comb begin
        n_valid = r_valid;
        n_stamp = r_stamp;
        n_elem  = r_elem;
        unique case (i_cmd.op)
            CELL_INSERT: begin
                if (!o_lt) begin
                    if (i_left_lt) begin
                        n_valid = 1'b1;
                        n_stamp = i_cmd.stamp;
                        n_elem  = i_cmd.element;
                    end else begin
                        n_valid = i_left.valid;
                        n_stamp = i_left.stamp;
                        n_elem  = i_left.element;
                    end
                end
            end
            CELL_REMOVE: begin
                if (o_match) begin
                    n_valid = i_right.valid;
                    n_stamp = i_right.stamp;
                    n_elem  = i_right.element;
                end
            end
            CELL_POP: begin
                n_valid = i_right.valid;
                n_stamp = i_right.stamp;
                n_elem  = i_right.element;
            end
            CELL_CLEAR: n_valid = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp <= n_stamp;
        r_elem  <= n_elem;
    end

    assign o_slot.valid   = r_valid;
    assign o_slot.stamp   = r_stamp;
    assign o_slot.element = r_elem;

endmodule

// ===== rtl/timed_event_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue
// Time-ordered event queue built as a chain of shifting slot cells.
// Result: strobe and response are registered, in the cycle after the request is taken.
// Throughput: one request per cycle; busy stays low, the cell row updates
// in the same edge that takes the request. Receiver cannot stall.
// Reset: queue empty, nothing pending, current time 1, simulation inactive.
// ----------------------------------------------------------------------------
module timed_event_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  teq_pkg::t_req i_req,
    output logic          o_strobe,
    output teq_pkg::t_rsp o_rsp,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);
    import teq_pkg::*;

    logic                 r_sim_active;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [ELEMENTS-1:0]  r_pending, n_pending;
    logic                 r_strobe;
    t_rsp                 r_rsp, n_rsp;

    t_cell_cmd            w_cmd;
    t_slot                w_slot  [ELEMENTS];
    logic                 w_lt    [ELEMENTS];
    logic                 w_match [ELEMENTS];

    logic                 accept;
    logic [SUM_W-1:0]     sum;
    logic [TIME_BITS-1:0] t_new;
    logic [TIME_BITS-1:0] limit_sat;
    logic                 in_range;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     head_idx;
    logic                 head_in_range;
    logic                 full;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    assign sum   = SUM_W'(r_now) + SUM_W'(i_req.delay);
    assign t_new = (sum > MAX_TIME) ? TIME_BITS'(MAX_TIME) : TIME_BITS'(sum);
    assign limit_sat = (i_req.limit_time > 63'(MAX_TIME)) ? TIME_BITS'(MAX_TIME)
                                                         : TIME_BITS'(i_req.limit_time);
    assign in_range      = int'(i_req.element) < ELEMENTS;
    assign idx           = IDX_W'(i_req.element);
    assign head_in_range = int'(w_slot[0].element) < ELEMENTS;
    assign head_idx      = IDX_W'(w_slot[0].element);
    assign full          = (r_count == CNT_W'(ELEMENTS));

    always_comb begin
        n_now            = r_now;
        n_count          = r_count;
        n_pending        = r_pending;
        w_cmd.op         = CELL_HOLD;
        w_cmd.stamp      = t_new;
        w_cmd.element    = i_req.element;
        n_rsp.status     = ST_NONE;
        n_rsp.event_element = '0;
        n_rsp.event_time = '0;
        unique case (t_op'(i_req.op))
            OP_SCHEDULE: begin
                if (!r_sim_active) begin
                    n_rsp.status = ST_INACTIVE;
                end else if (!in_range || r_pending[idx]) begin
                    n_rsp.status = ST_REPEATED;
                end else begin
                    n_rsp.status     = ST_SCHEDULED;
                    n_rsp.event_time = 63'(t_new);
                    if (!full) begin
                        w_cmd.op       = CELL_INSERT;
                        n_count        = r_count + CNT_W'(1);
                        n_pending[idx] = 1'b1;
                    end
                end
            end
            OP_CANCEL: begin
                if (!in_range || !r_pending[idx]) begin
                    n_rsp.status = ST_NOT_PENDING;
                end else begin
                    n_rsp.status   = ST_CANCELLED;
                    w_cmd.op       = CELL_REMOVE;
                    n_count        = r_count - CNT_W'(1);
                    n_pending[idx] = 1'b0;
                end
            end
            OP_POP: begin
                if (w_slot[0].valid && (w_slot[0].stamp <= limit_sat)) begin
                    n_rsp.status        = ST_POPPED;
                    n_rsp.event_element = w_slot[0].element;
                    n_rsp.event_time    = 63'(w_slot[0].stamp);
                    n_now               = w_slot[0].stamp;
                    w_cmd.op            = CELL_POP;
                    n_count             = r_count - CNT_W'(1);
                    if (head_in_range) begin
                        n_pending[head_idx] = 1'b0;
                    end
                end else begin
                    n_now = limit_sat;
                end
            end
            OP_CLEAR: begin
                w_cmd.op  = CELL_CLEAR;
                n_count   = '0;
                n_pending = '0;
            end
            default: ;
        endcase
        n_rsp.now_time    = 63'(n_now);
        n_rsp.queue_count = 6'(n_count);
        if (!accept) begin
            w_cmd.op = CELL_HOLD;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < ELEMENTS; gi++) begin : g_cell
            t_slot left_slot;
            t_slot right_slot;
            logic  left_lt;
            logic  left_match;
            if (gi == 0) begin : g_head
                assign left_slot  = '0;
                assign left_lt    = 1'b1;
                assign left_match = 1'b0;
            end else begin : g_mid
                assign left_slot  = w_slot[gi-1];
                assign left_lt    = w_lt[gi-1];
                assign left_match = w_match[gi-1];
            end
            if (gi == ELEMENTS - 1) begin : g_tail
                assign right_slot = '0;
            end else begin : g_next
                assign right_slot = w_slot[gi+1];
            end
            teq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cmd),
                .i_left       (left_slot),
                .i_right      (right_slot),
                .i_left_lt    (left_lt),
                .i_left_match (left_match),
                .o_slot       (w_slot[gi]),
                .o_lt         (w_lt[gi]),
                .o_match      (w_match[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sim_active <= 1'b0;
            r_now        <= TIME_BITS'(1);
            r_count      <= '0;
            r_pending    <= '0;
            r_strobe     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_sim_active <= i_cfg_data;
            end
            r_strobe <= accept;
            if (accept) begin
                r_now     <= n_now;
                r_count   <= n_count;
                r_pending <= n_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// ===== rtl/teq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_checker
// Port-level checks of the timed event queue, bound to the top level.
// ----------------------------------------------------------------------------
module teq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input teq_pkg::t_req i_req,
    input logic          o_strobe,
    input teq_pkg::t_rsp o_rsp
);
    import teq_pkg::*;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_strobe)
        else $error("request without result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy))
        else $error("result without request");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> int'(o_rsp.queue_count) <= ELEMENTS)
        else $error("queue count beyond capacity");

    a_pop_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_rsp.status == ST_POPPED |-> o_rsp.event_time == o_rsp.now_time)
        else $error("pop did not advance current time");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req.op == OP_CLEAR |=> o_rsp.queue_count == 6'd0)
        else $error("clear left events queued");

endmodule

bind timed_event_queue teq_checker u_teq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);
